// ----- hw/rtl/rgi_pkg.sv -----
package rgi_pkg;

    localparam logic [12:0] MAX_DIM = 13'd4096;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_EFFECT_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_LEFT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_TOP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_RIGHT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_BOTTOM  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd6;

    localparam logic MODE_GRAY   = 1'b0;
    localparam logic MODE_INVERT = 1'b1;

    localparam logic [7:0]  PIX_MAX     = 8'd255;
    localparam logic [17:0] LUMA_K_RED  = 18'd299;
    localparam logic [17:0] LUMA_K_GRN  = 18'd587;
    localparam logic [17:0] LUMA_K_BLU  = 18'd114;
    localparam logic [17:0] LUMA_ROUND  = 18'd500;
    localparam logic [18:0] LUMA_RECIP  = 19'd268436;
    localparam int          LUMA_SHIFT  = 28;

    typedef struct packed {
        logic [11:0] pixel_col;
        logic [11:0] pixel_row;
        logic [7:0]  red_in;
        logic [7:0]  green_in;
        logic [7:0]  blue_in;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       in_region;
    } pix_out_t;

    typedef struct packed {
        logic        mode;
        logic [12:0] x0;
        logic [12:0] x1;
        logic [12:0] y0;
        logic [12:0] y1;
    } bounds_t;

endpackage

// ----- hw/rtl/rgi_cfg.sv -----
module rgi_cfg
    import rgi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output bounds_t               bounds
);

    logic        mode_reg;
    logic [15:0] left_reg;
    logic [15:0] top_reg;
    logic [15:0] right_reg;
    logic [15:0] bottom_reg;
    logic [12:0] width_reg;
    logic [12:0] height_reg;

    logic [12:0] w_sat;
    logic [12:0] h_sat;
    logic [12:0] l_clamp;
    logic [12:0] r_clamp;
    logic [12:0] t_clamp;
    logic [12:0] b_clamp;
    bounds_t     bounds_next;
    bounds_t     bounds_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_GRAY;
            left_reg   <= '0;
            top_reg    <= '0;
            right_reg  <= '0;
            bottom_reg <= '0;
            width_reg  <= MAX_DIM;
            height_reg <= MAX_DIM;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_EFFECT_MODE:  mode_reg   <= cfg_data[0];
                REG_RECT_LEFT:    left_reg   <= cfg_data;
                REG_RECT_TOP:     top_reg    <= cfg_data;
                REG_RECT_RIGHT:   right_reg  <= cfg_data;
                REG_RECT_BOTTOM:  bottom_reg <= cfg_data;
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[12:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data[12:0];
                default:          ;
            endcase
        end
    end

    function automatic logic [12:0] clamp_bound(input logic [15:0] b, input logic [12:0] lim);
        logic [12:0] res;
        if (b[15])
            res = '0;
        else if (b >= {3'b000, lim})
            res = lim;
        else
            res = b[12:0];
        return res;
    endfunction

    always_comb
    begin
        w_sat   = (width_reg  > MAX_DIM) ? MAX_DIM : width_reg;
        h_sat   = (height_reg > MAX_DIM) ? MAX_DIM : height_reg;
        l_clamp = clamp_bound(left_reg, w_sat);
        r_clamp = clamp_bound(right_reg, w_sat);
        t_clamp = clamp_bound(top_reg, h_sat);
        b_clamp = clamp_bound(bottom_reg, h_sat);
        bounds_next.mode = mode_reg;
        bounds_next.x0   = (l_clamp < r_clamp) ? l_clamp : r_clamp;
        bounds_next.x1   = (l_clamp < r_clamp) ? r_clamp : l_clamp;
        bounds_next.y0   = (t_clamp < b_clamp) ? t_clamp : b_clamp;
        bounds_next.y1   = (t_clamp < b_clamp) ? b_clamp : t_clamp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bounds_reg <= '0;
        else
            bounds_reg <= bounds_next;
    end

    assign bounds = bounds_reg;

endmodule

// ----- hw/rtl/region_grayscale_invert.sv -----
// Region effect on a pixel stream: each pixel whose column and row fall inside the
// clamped rectangle is turned to BT.601 luma or color-inverted, all others pass
// through, and in_region tells which. One pixel is taken every cycle while in_stall
// is low; an accepted pixel passes through input, luma sum, reciprocal multiply and
// output register stages. Clamped bounds are registered behind the configuration
// registers, so a request may follow a write immediately.
module region_grayscale_invert
    import rgi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  pix_in_t               in_pixel,
    output logic                  out_valid,
    input  logic                  out_stall,
    output pix_out_t              out_pixel,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    bounds_t bounds;

    rgi_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .bounds    (bounds)
    );

    logic        s1_valid_reg;
    pix_in_t     s1_pix_reg;

    logic        s2_valid_reg;
    logic [17:0] s2_sum_reg;
    logic [17:0] s2_sum_next;
    logic        s2_inside_reg;
    logic        s2_inside_next;
    logic        s2_mode_reg;
    logic [7:0]  s2_red_reg;
    logic [7:0]  s2_green_reg;
    logic [7:0]  s2_blue_reg;

    logic        s3_valid_reg;
    logic [7:0]  s3_luma_reg;
    logic [36:0] s3_prod;
    logic        s3_inside_reg;
    logic        s3_mode_reg;
    logic [7:0]  s3_red_reg;
    logic [7:0]  s3_green_reg;
    logic [7:0]  s3_blue_reg;

    logic        out_valid_reg;
    pix_out_t    out_pixel_reg;
    pix_out_t    out_pixel_next;
    logic        out_mode_reg;

    logic        ready4;
    logic        ready3;
    logic        ready2;
    logic        ready1;

    assign ready4   = !out_valid_reg || !out_stall;
    assign ready3   = !s3_valid_reg || ready4;
    assign ready2   = !s2_valid_reg || ready3;
    assign ready1   = !s1_valid_reg || ready2;
    assign in_stall = !ready1;

    // hold input request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (ready1)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && in_valid)
            s1_pix_reg <= in_pixel;
    end

    always_comb
    begin
        s2_sum_next = LUMA_K_RED * {10'd0, s1_pix_reg.red_in}
                    + LUMA_K_GRN * {10'd0, s1_pix_reg.green_in}
                    + LUMA_K_BLU * {10'd0, s1_pix_reg.blue_in}
                    + LUMA_ROUND;
        s2_inside_next = ({1'b0, s1_pix_reg.pixel_col} >= bounds.x0)
                      && ({1'b0, s1_pix_reg.pixel_col} <  bounds.x1)
                      && ({1'b0, s1_pix_reg.pixel_row} >= bounds.y0)
                      && ({1'b0, s1_pix_reg.pixel_row} <  bounds.y1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (ready2)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ready2 && s1_valid_reg)
        begin
            s2_sum_reg    <= s2_sum_next;
            s2_inside_reg <= s2_inside_next;
            s2_mode_reg   <= bounds.mode;
            s2_red_reg    <= s1_pix_reg.red_in;
            s2_green_reg  <= s1_pix_reg.green_in;
            s2_blue_reg   <= s1_pix_reg.blue_in;
        end
    end

    // divide by 1000 through the scaled reciprocal
    assign s3_prod = {19'd0, s2_sum_reg} * {18'd0, LUMA_RECIP};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (ready3)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ready3 && s2_valid_reg)
        begin
            s3_luma_reg   <= s3_prod[LUMA_SHIFT+7:LUMA_SHIFT];
            s3_inside_reg <= s2_inside_reg;
            s3_mode_reg   <= s2_mode_reg;
            s3_red_reg    <= s2_red_reg;
            s3_green_reg  <= s2_green_reg;
            s3_blue_reg   <= s2_blue_reg;
        end
    end

    always_comb
    begin
        out_pixel_next.in_region = s3_inside_reg;
        if (!s3_inside_reg)
        begin
            out_pixel_next.red_out   = s3_red_reg;
            out_pixel_next.green_out = s3_green_reg;
            out_pixel_next.blue_out  = s3_blue_reg;
        end
        else if (s3_mode_reg == MODE_INVERT)
        begin
            out_pixel_next.red_out   = PIX_MAX - s3_red_reg;
            out_pixel_next.green_out = PIX_MAX - s3_green_reg;
            out_pixel_next.blue_out  = PIX_MAX - s3_blue_reg;
        end
        else
        begin
            out_pixel_next.red_out   = s3_luma_reg;
            out_pixel_next.green_out = s3_luma_reg;
            out_pixel_next.blue_out  = s3_luma_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ready4)
            out_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ready4 && s3_valid_reg)
        begin
            out_pixel_reg <= out_pixel_next;
            out_mode_reg  <= s3_mode_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_valid_reg && s3_valid_reg && out_valid_reg && out_stall)
        |-> in_stall)
        else $error("pipeline full under stall but input not stalled");

    a_gray_equal: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_pixel_reg.in_region && out_mode_reg == MODE_GRAY)
        |-> (out_pixel_reg.red_out == out_pixel_reg.green_out
             && out_pixel_reg.green_out == out_pixel_reg.blue_out))
        else $error("grayscale pixel channels differ");

    a_bounds_order: assert property (@(posedge clk) disable iff (!rst_n)
        (bounds.x0 <= bounds.x1) && (bounds.y0 <= bounds.y1)
        && (bounds.x1 <= MAX_DIM) && (bounds.y1 <= MAX_DIM))
        else $error("clamped bounds out of order");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && !ready3) |=> (s3_valid_reg && $stable(s3_luma_reg)))
        else $error("stalled stage lost its data");

endmodule
